[hw/rtl/broadcast_stride_address_generator_macros.svh]
// Assertion macros for the module that checks its own logic.
// They expect signals named clk and arst_n in the scope of use.
`ifndef BROADCAST_STRIDE_ADDRESS_GENERATOR_MACROS_SVH
`define BROADCAST_STRIDE_ADDRESS_GENERATOR_MACROS_SVH

`define BSAG_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`define BSAG_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/bsag_pkg.sv]
package bsag_pkg;

	localparam int NUM_DIMS    = 3;
	localparam int DIM_CNT_W   = 2;
	localparam int OFS_W       = 48;
	localparam int STRIDE_W    = 31;
	localparam int EXT_SLOT_W  = 16;
	localparam int EXTENTS_W   = NUM_DIMS * EXT_SLOT_W;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 48;
	localparam int IN_TDATA_W  = 8;
	localparam int OUT_TDATA_W = 3 * OFS_W;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DIM_COUNT  = 3'd0,
		REG_EXTENTS    = 3'd1,
		REG_A_STRIDE_0 = 3'd2,
		REG_A_STRIDE_1 = 3'd3,
		REG_A_STRIDE_2 = 3'd4,
		REG_B_STRIDE_0 = 3'd5,
		REG_B_STRIDE_1 = 3'd6,
		REG_B_STRIDE_2 = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic [DIM_CNT_W-1:0]               dim_count;
		logic [EXTENTS_W-1:0]               extents;
		logic [NUM_DIMS-1:0][STRIDE_W-1:0]  a_stride;
		logic [NUM_DIMS-1:0][STRIDE_W-1:0]  b_stride;
	} cfg_t;

	typedef struct packed {
		logic [OFS_W-1:0] lin;
		logic             last;
	} meta_t;

endpackage

[hw/rtl/bsag_cfg.sv]
module bsag_cfg
	import bsag_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dim_count <= DIM_CNT_W'(1);
			cfg_q.extents   <= EXTENTS_W'(1);
			cfg_q.a_stride  <= '0;
			cfg_q.b_stride  <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_DIM_COUNT:  cfg_q.dim_count   <= cfg_wdata[DIM_CNT_W-1:0];
				REG_EXTENTS:    cfg_q.extents     <= cfg_wdata[EXTENTS_W-1:0];
				REG_A_STRIDE_0: cfg_q.a_stride[0] <= cfg_wdata[STRIDE_W-1:0];
				REG_A_STRIDE_1: cfg_q.a_stride[1] <= cfg_wdata[STRIDE_W-1:0];
				REG_A_STRIDE_2: cfg_q.a_stride[2] <= cfg_wdata[STRIDE_W-1:0];
				REG_B_STRIDE_0: cfg_q.b_stride[0] <= cfg_wdata[STRIDE_W-1:0];
				REG_B_STRIDE_1: cfg_q.b_stride[1] <= cfg_wdata[STRIDE_W-1:0];
				REG_B_STRIDE_2: cfg_q.b_stride[2] <= cfg_wdata[STRIDE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[hw/rtl/bsag_step.sv]
module bsag_step
	import bsag_pkg::*;
#(
	parameter int EXTENT_BITS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  cfg_t                                  cfg,
	input  logic                                  fire,
	input  logic                                  restart,
	output logic                                  emit,
	output logic [NUM_DIMS-1:0][EXTENT_BITS-1:0]  nxt_idx,
	output meta_t                                 nxt_meta
);

	logic [NUM_DIMS-1:0][EXTENT_BITS-1:0] idx_q;
	logic [OFS_W-1:0]                     lin_q;
	logic                                 walk_q;

	logic [DIM_CNT_W-1:0]                 n_used;
	logic [NUM_DIMS-1:0]                  used;
	logic [NUM_DIMS-1:0][EXTENT_BITS-1:0] ext;
	logic [NUM_DIMS-1:0][EXTENT_BITS:0]   inc;
	logic [NUM_DIMS-1:0]                  wrap;
	logic [NUM_DIMS-1:0][EXTENT_BITS-1:0] adv_idx;
	logic [NUM_DIMS-1:0]                  at_end;
	logic                                 zero_ext;
	logic                                 carry;
	logic                                 step_req;

	assign n_used = (cfg.dim_count == '0) ? DIM_CNT_W'(1) : cfg.dim_count;

	// The innermost used dimension always counts; a carry ripples outward.
	always_comb begin
		carry    = 1'b1;
		zero_ext = 1'b0;
		for (int k = NUM_DIMS - 1; k >= 0; k--) begin
			used[k] = DIM_CNT_W'(k) < n_used;
			ext[k]  = cfg.extents[k*EXT_SLOT_W +: EXTENT_BITS];
			inc[k]  = {1'b0, idx_q[k]} + (EXTENT_BITS+1)'(1);
			wrap[k] = inc[k] >= {1'b0, ext[k]};
			if (used[k]) begin
				if (ext[k] == '0) begin
					zero_ext = 1'b1;
				end
				if (carry) begin
					adv_idx[k] = wrap[k] ? '0 : inc[k][EXTENT_BITS-1:0];
				end else begin
					adv_idx[k] = idx_q[k];
				end
				carry = carry & wrap[k];
			end else begin
				adv_idx[k] = '0;
			end
		end
	end

	always_comb begin
		for (int k = 0; k < NUM_DIMS; k++) begin
			nxt_idx[k] = restart ? '0 : adv_idx[k];
			at_end[k]  = !used[k] ||
				(({1'b0, nxt_idx[k]} + (EXTENT_BITS+1)'(1)) >= {1'b0, ext[k]});
		end
	end

	assign step_req      = fire && (restart || walk_q);
	assign emit          = step_req && !zero_ext;
	assign nxt_meta.lin  = restart ? '0 : lin_q + OFS_W'(1);
	assign nxt_meta.last = &at_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			lin_q  <= '0;
			walk_q <= 1'b0;
		end else if (emit) begin
			idx_q  <= nxt_idx;
			lin_q  <= nxt_meta.lin;
			walk_q <= !nxt_meta.last;
		end else if (step_req) begin
			walk_q <= 1'b0;
			if (restart) begin
				idx_q <= '0;
				lin_q <= '0;
			end
		end
	end

endmodule

[hw/rtl/bsag_offs.sv]
module bsag_offs
	import bsag_pkg::*;
#(
	parameter int EXTENT_BITS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  cfg_t                                  cfg,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [NUM_DIMS-1:0][EXTENT_BITS-1:0]  in_idx,
	input  meta_t                                 in_meta,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [OUT_TDATA_W-1:0]                out_data,
	output logic                                  out_last
);

	localparam int PROD_W = STRIDE_W + EXTENT_BITS;

	logic                                 v_s1;
	logic [NUM_DIMS-1:0][EXTENT_BITS-1:0] idx_s1;
	meta_t                                meta_s1;

	logic                                 v_s2;
	logic [NUM_DIMS-1:0][PROD_W-1:0]      a_prod_s2;
	logic [NUM_DIMS-1:0][PROD_W-1:0]      b_prod_s2;
	meta_t                                meta_s2;

	logic                                 v_s3;
	logic [OFS_W-1:0]                     a_ofs_s3;
	logic [OFS_W-1:0]                     b_ofs_s3;
	meta_t                                meta_s3;

	logic en1;
	logic en2;
	logic en3;

	assign en3      = !v_s3 || out_ready;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign in_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) begin
				v_s1 <= in_valid;
			end
			if (en2) begin
				v_s2 <= v_s1;
			end
			if (en3) begin
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && in_valid) begin
			idx_s1  <= in_idx;
			meta_s1 <= in_meta;
		end
		if (en2 && v_s1) begin
			for (int k = 0; k < NUM_DIMS; k++) begin
				a_prod_s2[k] <= PROD_W'(idx_s1[k]) * PROD_W'(cfg.a_stride[k]);
				b_prod_s2[k] <= PROD_W'(idx_s1[k]) * PROD_W'(cfg.b_stride[k]);
			end
			meta_s2 <= meta_s1;
		end
		if (en3 && v_s2) begin
			a_ofs_s3 <= OFS_W'(a_prod_s2[0]) + OFS_W'(a_prod_s2[1]) + OFS_W'(a_prod_s2[2]);
			b_ofs_s3 <= OFS_W'(b_prod_s2[0]) + OFS_W'(b_prod_s2[1]) + OFS_W'(b_prod_s2[2]);
			meta_s3  <= meta_s2;
		end
	end

	assign out_valid = v_s3;
	assign out_data  = {b_ofs_s3, a_ofs_s3, meta_s3.lin};
	assign out_last  = meta_s3.last;

endmodule

[hw/rtl/broadcast_stride_address_generator.sv]
// Strided broadcast address generator. Each accepted item either restarts the
// walk (restart set) or advances it by one element, and yields at most one
// result: the row-major output offset, the operand a and b offsets and a last
// flag. One item is taken every clock cycle while the output is not stalled;
// the rate is set by the index counter update, which does the full carry across
// all three dimensions combinationally. A result passes the index register, the
// multiplier register and the sum register on its way out. Restarts with a
// zero extent and advances after the final element give no result.
module broadcast_stride_address_generator
	import bsag_pkg::*;
#(
	parameter int EXTENT_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,   // restart
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,   // out_offset, a_offset, b_offset
	output logic                   m_tlast,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

	cfg_t                                 cfg;
	logic                                 fire;
	logic                                 emit;
	logic [NUM_DIMS-1:0][EXTENT_BITS-1:0] nxt_idx;
	meta_t                                step_meta;

	assign fire = s_tvalid && s_tready;

	bsag_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	bsag_step #(
		.EXTENT_BITS (EXTENT_BITS)
	) u_step (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.fire     (fire),
		.restart  (s_tdata[0]),
		.emit     (emit),
		.nxt_idx  (nxt_idx),
		.nxt_meta (step_meta)
	);

	bsag_offs #(
		.EXTENT_BITS (EXTENT_BITS)
	) u_offs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (emit),
		.in_ready  (s_tready),
		.in_idx    (nxt_idx),
		.in_meta   (step_meta),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata),
		.out_last  (m_tlast)
	);

`include "broadcast_stride_address_generator_macros.svh"

	`BSAG_ASSERT_IMPL(a_restart_count_zero, emit && s_tdata[0], step_meta.lin == '0, "restart result must have offset zero")
	`BSAG_ASSERT_IMPL(a_no_result_after_last, emit && step_meta.last ##1 fire && !s_tdata[0], !emit, "advance after the final element gave a result")
	`BSAG_ASSERT_NEXT(a_advance_counts_up, emit && !s_tdata[0] && !step_meta.last ##1 fire && !s_tdata[0] && emit, step_meta.lin != '0 || $past(step_meta.lin) != '1, "offset count did not advance")

endmodule

[sim/broadcast_stride_address_generator_test.sv]
module broadcast_stride_address_generator_test;
	import bsag_pkg::*;

	localparam int EXT_BITS = 16;
	localparam int ITEM_TOTAL = 1800;
	localparam int CALM_ITEMS = 250;
	localparam int HOLD_PHASE = 12;
	localparam int HOLD_CYCLES = 300;
	localparam logic [EXT_SLOT_W-1:0] EXT_MASK = EXT_SLOT_W'((32'd1 << EXT_BITS) - 1);
	localparam logic [CFG_DATA_W-1:0] STRIDE_MAX = 48'h0000_4000_0000;

	typedef struct packed {
		logic [OFS_W-1:0] lin;
		logic [OFS_W-1:0] a_ofs;
		logic [OFS_W-1:0] b_ofs;
		logic             last;
	} addr_t;

	typedef enum {ROW_CFG, ROW_ITEM} row_kind_t;
	typedef enum {CHK_MODEL, CHK_NONE, CHK_FIXED} row_check_t;

	typedef struct {
		row_kind_t             kind;
		cfg_reg_t              reg_id;
		logic [CFG_DATA_W-1:0] value;
		bit                    restart;
		row_check_t            chk;
		addr_t                 want;
	} plan_row_t;

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   m_tlast;
	logic                   cfg_we;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_wdata;

	broadcast_stride_address_generator #(
		.EXTENT_BITS(EXT_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	logic [DIM_CNT_W-1:0]  reg_dims;
	logic [EXTENTS_W-1:0]  reg_extents;
	logic [STRIDE_W-1:0]   reg_a_stride [NUM_DIMS];
	logic [STRIDE_W-1:0]   reg_b_stride [NUM_DIMS];
	logic [EXT_SLOT_W-1:0] walk_index [NUM_DIMS];
	logic [OFS_W-1:0]      walk_count;
	bit                    walking;

	addr_t pending_addrs[$];
	int    mismatches = 0;
	int    items_accepted = 0;
	bit    calm = 1'b0;
	bit    hold_req = 1'b0;
	bit    hold_done = 1'b0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin : watchdog
		#2000000;
		$display("broadcast_stride_address_generator test failed");
		$finish;
	end

	function automatic int dims_in_use();
		return (reg_dims == '0) ? 1 : int'(reg_dims);
	endfunction

	function automatic logic [EXT_SLOT_W:0] extent_of(int k);
		return {1'b0, reg_extents[EXT_SLOT_W*k +: EXT_SLOT_W] & EXT_MASK};
	endfunction

	function automatic addr_t emit_addr(int n);
		addr_t            res;
		logic [OFS_W-1:0] ao;
		logic [OFS_W-1:0] bo;
		bit               fin;
		ao = '0;
		bo = '0;
		fin = 1'b1;
		for (int k = 0; k < NUM_DIMS; k++) begin
			if (k >= n) walk_index[k] = '0;
			walk_index[k] = walk_index[k] & EXT_MASK;
			ao = ao + OFS_W'(walk_index[k]) * OFS_W'(reg_a_stride[k]);
			bo = bo + OFS_W'(walk_index[k]) * OFS_W'(reg_b_stride[k]);
			if (k < n && {1'b0, walk_index[k]} + 17'd1 < extent_of(k)) fin = 1'b0;
		end
		res.lin = walk_count;
		res.a_ofs = ao;
		res.b_ofs = bo;
		res.last = fin;
		walking = !fin;
		return res;
	endfunction

	function automatic bit walk_step(input bit restart, output addr_t res);
		int n;
		bit zero_ext;
		bit carry;
		n = dims_in_use();
		zero_ext = 1'b0;
		carry = 1'b1;
		res = '0;
		for (int k = 0; k < n; k++)
			if (extent_of(k) == '0) zero_ext = 1'b1;
		if (restart) begin
			for (int k = 0; k < NUM_DIMS; k++) walk_index[k] = '0;
			walk_count = '0;
			if (zero_ext) begin
				walking = 1'b0;
				return 1'b0;
			end
			res = emit_addr(n);
			return 1'b1;
		end
		if (!walking) return 1'b0;
		if (zero_ext) begin
			walking = 1'b0;
			return 1'b0;
		end
		for (int k = NUM_DIMS - 1; k >= 0; k--) begin
			if (carry && k < n) begin
				if ({1'b0, walk_index[k] & EXT_MASK} + 17'd1 >= extent_of(k)) begin
					walk_index[k] = '0;
				end else begin
					walk_index[k] = (walk_index[k] & EXT_MASK) + 1'b1;
					carry = 1'b0;
				end
			end
		end
		walk_count = walk_count + 1'b1;
		res = emit_addr(n);
		return 1'b1;
	endfunction

	function automatic plan_row_t cfg_row(cfg_reg_t r, logic [CFG_DATA_W-1:0] v);
		return '{ROW_CFG, r, v, 1'b0, CHK_NONE, '0};
	endfunction

	function automatic plan_row_t item_row(bit restart, row_check_t chk, addr_t want);
		return '{ROW_ITEM, REG_DIM_COUNT, '0, restart, chk, want};
	endfunction

	function automatic logic [EXT_SLOT_W-1:0] pick_extent();
		case ($urandom_range(0, 15))
			0: return '0;
			1: return 16'hFFFF;
			2: return 16'($urandom);
			default: return 16'($urandom_range(1, 5));
		endcase
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_stride();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return STRIDE_MAX;
			2: return CFG_DATA_W'($urandom_range(0, 32'h3FFF_FFFF));
			default: return CFG_DATA_W'($urandom_range(1, 9));
		endcase
	endfunction

	task automatic write_reg(input cfg_reg_t r, input logic [CFG_DATA_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_index <= r;
		cfg_wdata <= v;
		@(posedge clk);
		case (r)
			REG_DIM_COUNT:  reg_dims = v[DIM_CNT_W-1:0];
			REG_EXTENTS:    reg_extents = v[EXTENTS_W-1:0];
			REG_A_STRIDE_0: reg_a_stride[0] = v[STRIDE_W-1:0];
			REG_A_STRIDE_1: reg_a_stride[1] = v[STRIDE_W-1:0];
			REG_A_STRIDE_2: reg_a_stride[2] = v[STRIDE_W-1:0];
			REG_B_STRIDE_0: reg_b_stride[0] = v[STRIDE_W-1:0];
			REG_B_STRIDE_1: reg_b_stride[1] = v[STRIDE_W-1:0];
			REG_B_STRIDE_2: reg_b_stride[2] = v[STRIDE_W-1:0];
			default: ;
		endcase
	endtask

	task automatic send_item(input bit restart, input row_check_t chk, input addr_t want);
		addr_t got;
		bit    ready_seen;
		bit    produced;
		s_tvalid <= 1'b1;
		s_tdata <= IN_TDATA_W'(restart);
		do begin
			@(negedge clk);
			ready_seen = s_tready;
			@(posedge clk);
		end while (!ready_seen);
		items_accepted++;
		produced = walk_step(restart, got);
		case (chk)
			CHK_MODEL: if (produced) pending_addrs.push_back(got);
			CHK_FIXED: pending_addrs.push_back(want);
			default: ;
		endcase
	endtask

	task automatic sender_pause();
		calm = (items_accepted >= ITEM_TOTAL - CALM_ITEMS);
		if (!calm && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (pending_addrs.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic randomize_regs();
		if ($urandom_range(0, 1) != 0)
			write_reg(REG_DIM_COUNT, CFG_DATA_W'($urandom_range(0, 3)));
		if ($urandom_range(0, 1) != 0)
			write_reg(REG_EXTENTS, {pick_extent(), pick_extent(), pick_extent()});
		for (int r = REG_A_STRIDE_0; r <= REG_B_STRIDE_2; r++)
			if ($urandom_range(0, 1) != 0) write_reg(cfg_reg_t'(r), pick_stride());
	endtask

	task automatic run_phase();
		int count;
		bit restart;
		count = $urandom_range(10, 60);
		for (int i = 0; i < count; i++) begin
			if (i == 0) restart = ($urandom_range(0, 3) != 0);
			else restart = ($urandom_range(0, 11) == 0);
			sender_pause();
			send_item(restart, CHK_MODEL, '0);
		end
	endtask

	initial begin : sink_ready
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req && !hold_done) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				repeat (calm ? 1 : $urandom_range(1, 16)) @(posedge clk);
			end
		end
	end

	always @(negedge clk) begin : check_results
		addr_t got;
		addr_t want;
		if (arst_n === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1) begin
			got = '{m_tdata[OFS_W-1:0], m_tdata[2*OFS_W-1:OFS_W],
				m_tdata[3*OFS_W-1:2*OFS_W], m_tlast};
			if (pending_addrs.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected item: out %h a %h b %h last %b",
						got.lin, got.a_ofs, got.b_ofs, got.last);
			end else begin
				want = pending_addrs.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected out %h a %h b %h last %b, got out %h a %h b %h last %b",
							want.lin, want.a_ofs, want.b_ofs, want.last,
							got.lin, got.a_ofs, got.b_ofs, got.last);
				end
			end
		end
	end

	initial begin : stimulus
		plan_row_t plan[$];
		bit        prev_cfg;
		int        phase;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		cfg_we <= 1'b0;
		cfg_index <= REG_DIM_COUNT;
		cfg_wdata <= '0;
		arst_n <= 1'b0;
		reg_dims = 2'd1;
		reg_extents = 48'd1;
		for (int k = 0; k < NUM_DIMS; k++) begin
			reg_a_stride[k] = '0;
			reg_b_stride[k] = '0;
			walk_index[k] = '0;
		end
		walk_count = '0;
		walking = 1'b0;

		// An advance with no walk, a single element walk, and an advance past its end.
		plan.push_back(item_row(1'b0, CHK_NONE, '0));
		plan.push_back(item_row(1'b1, CHK_FIXED, '{48'd0, 48'd0, 48'd0, 1'b1}));
		plan.push_back(item_row(1'b0, CHK_NONE, '0));
		// Full walk of a 2x2x2 tensor with the largest strides and one broadcast.
		plan.push_back(cfg_row(REG_DIM_COUNT, 48'd3));
		plan.push_back(cfg_row(REG_EXTENTS, 48'h0002_0002_0002));
		plan.push_back(cfg_row(REG_A_STRIDE_0, STRIDE_MAX));
		plan.push_back(cfg_row(REG_A_STRIDE_1, STRIDE_MAX));
		plan.push_back(cfg_row(REG_A_STRIDE_2, STRIDE_MAX));
		plan.push_back(cfg_row(REG_B_STRIDE_0, 48'd1));
		plan.push_back(cfg_row(REG_B_STRIDE_1, 48'd0));
		plan.push_back(cfg_row(REG_B_STRIDE_2, 48'h0000_2AAA_AAAA));
		plan.push_back(item_row(1'b1, CHK_FIXED, '{48'd0, 48'd0, 48'd0, 1'b0}));
		for (int i = 0; i < 7; i++) plan.push_back(item_row(1'b0, CHK_MODEL, '0));
		plan.push_back(item_row(1'b0, CHK_NONE, '0));
		// A dimension count of zero acts as one; largest extents.
		plan.push_back(cfg_row(REG_DIM_COUNT, 48'd0));
		plan.push_back(cfg_row(REG_EXTENTS, 48'hFFFF_FFFF_FFFF));
		plan.push_back(item_row(1'b1, CHK_FIXED, '{48'd0, 48'd0, 48'd0, 1'b0}));
		plan.push_back(item_row(1'b0, CHK_MODEL, '0));
		plan.push_back(item_row(1'b0, CHK_MODEL, '0));
		// Extents shrink mid-walk, so the index wraps back to element zero.
		plan.push_back(cfg_row(REG_DIM_COUNT, 48'd3));
		plan.push_back(cfg_row(REG_EXTENTS, 48'h0001_0001_0002));
		plan.push_back(item_row(1'b0, CHK_MODEL, '0));
		// A zero extent ends the walk and blocks a restart.
		plan.push_back(cfg_row(REG_DIM_COUNT, 48'd2));
		plan.push_back(cfg_row(REG_EXTENTS, 48'h0001_0000_0002));
		plan.push_back(item_row(1'b0, CHK_NONE, '0));
		plan.push_back(item_row(1'b1, CHK_NONE, '0));
		plan.push_back(cfg_row(REG_EXTENTS, 48'h0001_0001_0002));
		plan.push_back(item_row(1'b0, CHK_NONE, '0));
		plan.push_back(item_row(1'b1, CHK_MODEL, '0));
		plan.push_back(item_row(1'b0, CHK_MODEL, '0));

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		prev_cfg = 1'b0;
		foreach (plan[i]) begin
			if (plan[i].kind == ROW_CFG) begin
				if (!prev_cfg) drain_results();
				write_reg(plan[i].reg_id, plan[i].value);
				prev_cfg = 1'b1;
			end else begin
				if (prev_cfg) cfg_we <= 1'b0;
				prev_cfg = 1'b0;
				sender_pause();
				send_item(plan[i].restart, plan[i].chk, plan[i].want);
			end
		end

		phase = 0;
		while (items_accepted < ITEM_TOTAL) begin
			if (calm) begin
				run_phase();
			end else if (phase == HOLD_PHASE) begin
				drain_results();
				// Long walk against a stalled receiver so the input backs up.
				write_reg(REG_DIM_COUNT, 48'd1);
				write_reg(REG_EXTENTS, 48'h0000_0000_FFFF);
				cfg_we <= 1'b0;
				hold_req = 1'b1;
				send_item(1'b1, CHK_MODEL, '0);
				repeat (80) send_item(1'b0, CHK_MODEL, '0);
			end else begin
				drain_results();
				randomize_regs();
				cfg_we <= 1'b0;
				run_phase();
			end
			phase++;
		end

		s_tvalid <= 1'b0;
		for (int w = 0; w < 20000 && pending_addrs.size() != 0; w++) @(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0 && pending_addrs.size() == 0) begin
			$display("broadcast_stride_address_generator test passed");
		end else begin
			$display("broadcast_stride_address_generator test failed");
		end
		$finish;
	end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/bsag_pkg.sv
hw/rtl/bsag_cfg.sv
hw/rtl/bsag_step.sv
hw/rtl/bsag_offs.sv
hw/rtl/broadcast_stride_address_generator.sv
sim/broadcast_stride_address_generator_test.sv
